/* hdl/cpfc_pkg.sv */
// Package with the word types, codes and constants of the control packet frame checker.
`default_nettype none

package cpfc_pkg;

    // Field widths.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned FlagW  = 16;
    localparam int unsigned ParamW = 16;
    localparam int unsigned AngleW = 32;
    localparam int unsigned IndexW = 4;
    localparam int unsigned KindW  = 2;
    localparam int unsigned StatW  = 2;
    localparam int unsigned RegIdxW = 2;

    // Packet lengths in bytes and the index at which the byte counter stops.
    localparam int unsigned VehicleLen = 8;
    localparam int unsigned GimbalLen  = 12;
    localparam int unsigned IndexSat   = 13;

    // Byte positions inside a packet.
    localparam logic [IndexW-1:0] IdxFlagLo     = 4'd0;
    localparam logic [IndexW-1:0] IdxFlagHi     = 4'd1;
    localparam logic [IndexW-1:0] IdxCommand    = 4'd2;
    localparam logic [IndexW-1:0] IdxWordAFirst = 4'd3;
    localparam logic [IndexW-1:0] IdxWordALast  = 4'd6;
    localparam logic [IndexW-1:0] IdxWordBFirst = 4'd7;
    localparam logic [IndexW-1:0] IdxWordBLast  = 4'd10;
    localparam logic [IndexW-1:0] IdxVehicleEnd = IndexW'(VehicleLen - 1);
    localparam logic [IndexW-1:0] IdxGimbalEnd  = IndexW'(GimbalLen - 1);
    localparam logic [IndexW-1:0] IdxSat        = IndexW'(IndexSat);

    // Packet kind codes.
    localparam logic [KindW-1:0] KindPlain   = 2'd0;
    localparam logic [KindW-1:0] KindVehicle = 2'd1;
    localparam logic [KindW-1:0] KindGimbal  = 2'd2;

    // Parse status codes.
    localparam logic [StatW-1:0] StatOk       = 2'd0;
    localparam logic [StatW-1:0] StatBadLen   = 2'd1;
    localparam logic [StatW-1:0] StatBadCheck = 2'd2;

    // Configuration register indexes.
    localparam logic [RegIdxW-1:0] RegVehicleFlag = 2'd0;
    localparam logic [RegIdxW-1:0] RegGimbalFlag  = 2'd1;

    // Input word: one packet byte.
    typedef struct packed {
        logic [ByteW-1:0] rx_byte;
        logic             final_byte;
    } in_word_t;

    // Output word: one parsed packet.
    typedef struct packed {
        logic [KindW-1:0]  packet_kind;
        logic [StatW-1:0]  parse_status;
        logic [ByteW-1:0]  command_code;
        logic [ParamW-1:0] first_param;
        logic [ParamW-1:0] second_param;
        logic [AngleW-1:0] pitch_word;
        logic [AngleW-1:0] yaw_word;
    } out_word_t;

endpackage

`default_nettype wire

/* hdl/control_packet_frame_checker_core.sv */
// Timing: the result word of a packet is registered in the cycle its final byte is accepted
// and is shown in the following cycle. Throughput: one byte per cycle; any byte, final or not, stalls
// while the previous result word is still held and not taken.
// Reset: asynchronous, active low; clears both start flags, the byte counter, the checksum
// and the result valid. Flag writes take effect at once and keep the packet state.
// Top level of the control packet frame checker.
`default_nettype none

module control_packet_frame_checker_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire cpfc_pkg::in_word_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output cpfc_pkg::out_word_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [cpfc_pkg::RegIdxW-1:0]    cfg_index,
    input  wire logic [cpfc_pkg::FlagW-1:0]      cfg_data
);
    import cpfc_pkg::*;

    // Configuration and packet state.
    logic [FlagW-1:0]  vehicle_flag_reg;
    logic [FlagW-1:0]  gimbal_flag_reg;
    logic [IndexW-1:0] byte_index_reg;
    logic [IndexW-1:0] byte_index_next;
    logic [ByteW-1:0]  running_sum_reg;
    logic [ByteW-1:0]  running_sum_next;
    logic [FlagW-1:0]  flag_bytes_reg;
    logic [FlagW-1:0]  flag_bytes_next;
    logic [ByteW-1:0]  command_reg;
    logic [AngleW-1:0] word_a_reg;
    logic [AngleW-1:0] word_b_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;
    out_word_t         out_data_next;

    logic              in_fire;
    logic              out_fire;
    logic [1:0]        lane;
    logic [KindW-1:0]  kind;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Byte lane inside word A or word B for the current index.
    assign lane = byte_index_reg[1:0] + 2'd1;

    // Start flag including the byte now arriving, counter and checksum updates.
    always_comb
    begin
        flag_bytes_next = flag_bytes_reg;
        if (byte_index_reg == IdxFlagLo)
        begin
            flag_bytes_next[7:0] = in_data.rx_byte;
        end
        else if (byte_index_reg == IdxFlagHi)
        begin
            flag_bytes_next[15:8] = in_data.rx_byte;
        end

        if (in_data.final_byte)
        begin
            byte_index_next  = '0;
            running_sum_next = '0;
        end
        else
        begin
            byte_index_next  = (byte_index_reg < IdxSat) ? byte_index_reg + 4'd1
                                                         : byte_index_reg;
            running_sum_next = (byte_index_reg >= IdxCommand)
                             ? running_sum_reg + in_data.rx_byte : running_sum_reg;
        end
    end

    // Classify the packet and build the result word on the final byte.
    always_comb
    begin
        kind = KindPlain;
        if (byte_index_reg != IdxFlagLo)
        begin
            if (flag_bytes_next == vehicle_flag_reg)
            begin
                kind = KindVehicle;
            end
            else if (flag_bytes_next == gimbal_flag_reg)
            begin
                kind = KindGimbal;
            end
        end

        out_data_next              = '0;
        out_data_next.packet_kind  = kind;
        case (kind)
            KindVehicle:
            begin
                if (byte_index_reg != IdxVehicleEnd)
                begin
                    out_data_next.parse_status = StatBadLen;
                end
                else
                begin
                    out_data_next.parse_status = (running_sum_reg == in_data.rx_byte)
                                               ? StatOk : StatBadCheck;
                    out_data_next.command_code = command_reg;
                    out_data_next.first_param  = word_a_reg[15:0];
                    out_data_next.second_param = word_a_reg[31:16];
                end
            end
            KindGimbal:
            begin
                if (byte_index_reg != IdxGimbalEnd)
                begin
                    out_data_next.parse_status = StatBadLen;
                end
                else
                begin
                    out_data_next.parse_status = (running_sum_reg == in_data.rx_byte)
                                               ? StatOk : StatBadCheck;
                    out_data_next.command_code = command_reg;
                    out_data_next.pitch_word   = word_a_reg;
                    out_data_next.yaw_word     = word_b_reg;
                end
            end
            default:
            begin
                out_data_next.parse_status = StatOk;
            end
        endcase
    end

    // Control state: flags, counter, checksum and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vehicle_flag_reg <= '0;
            gimbal_flag_reg  <= '0;
            byte_index_reg   <= '0;
            running_sum_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    RegVehicleFlag: vehicle_flag_reg <= cfg_data;
                    RegGimbalFlag:  gimbal_flag_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (in_fire)
            begin
                byte_index_reg  <= byte_index_next;
                running_sum_reg <= running_sum_next;
            end
            if (in_fire && in_data.final_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Captured packet bytes and the result word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            flag_bytes_reg <= flag_bytes_next;
            case (byte_index_reg) inside
                IdxCommand:
                begin
                    command_reg <= in_data.rx_byte;
                end
                [IdxWordAFirst:IdxWordALast]:
                begin
                    word_a_reg[8*lane +: 8] <= in_data.rx_byte;
                end
                [IdxWordBFirst:IdxWordBLast]:
                begin
                    word_b_reg[8*lane +: 8] <= in_data.rx_byte;
                end
                default:
                begin
                end
            endcase
            if (in_data.final_byte)
            begin
                out_data_reg <= out_data_next;
            end
        end
    end

`ifndef SYNTHESIS
    // The byte counter never runs past its saturation point.
    assert property (@(posedge clk) disable iff (!rst_n) byte_index_reg <= IdxSat)
        else $error("byte counter past saturation");

    // A final byte leaves the counter and checksum cleared for the next packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.final_byte |=> byte_index_reg == '0 && running_sum_reg == '0)
        else $error("packet state not cleared after final byte");

    // A new result appears only after a final byte was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && in_data.final_byte))
        else $error("result without final byte");

    // Plain commands always report status ok and no command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.packet_kind == KindPlain
        |-> out_data_reg.parse_status == StatOk && out_data_reg.command_code == '0)
        else $error("plain command with nonzero fields");
`endif

endmodule

`default_nettype wire
